/* hw/rtl/wsc_pkg.sv */
// wsc_pkg: shared types and constants of the wheel speed controller
// register indexes, reset values, band table, drive codes, divider status
// used by every file under hw/rtl
package wsc_pkg;

    localparam int TGT_W      = 13;
    localparam int MEAS_W     = 16;
    localparam int MAG_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int DUTY_W     = 8;
    localparam int DIR_W      = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FF_TABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_KP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_LIMITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STALL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd6;

    // reset values
    localparam logic [63:0] RST_FF_TABLE   = 64'h0;
    localparam logic [15:0] RST_GAIN_KP    = 16'h0000;
    localparam logic [15:0] RST_PWM_LIMITS = 16'hFF00;
    localparam logic [7:0]  RST_SLEW_STEP  = 8'hFF;
    localparam logic [24:0] RST_STALL      = 25'h0;
    localparam logic [9:0]  RST_INTERVAL   = 10'd100;
    localparam logic [1:0]  RST_MODE       = 2'd0;

    // drive direction codes
    localparam logic [DIR_W-1:0] DIR_OFF = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV = 2'd2;

    // upper bounds of the feedforward speed bands, whole counts per 100 ms
    localparam int NUM_BANDS = 8;
    localparam logic [7:0] BAND_TOP [0:NUM_BANDS-2] =
        '{8'd12, 8'd20, 8'd30, 8'd40, 8'd55, 8'd70, 8'd80};

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* hw/rtl/wheel_speed_controller_unit.sv */
// wheel_speed_controller_unit: per-wheel speed loop, one word in, one word out
// depends on wsc_pkg and wsc_divider
//
// channel   dir  handshake               payload
// s_        in   s_tvalid / s_tready     tdata target_speed, measured_count; tuser clear_fault
// m_        out  m_tvalid / m_tready     tdata duty; tuser drive_dir, fault
// cfg_      in   cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
// a zero target or a latched fault skips the datapath and gives an off word with zero duty
// any other word runs a shared multiplier over four products and a registered reciprocal
// divide, then the clamp and slew states, before its word goes to the output register
// s_tready is high only while the sequencer is idle
// a result waits in the output register; a stall on m_ holds the next result back
// synchronous active-low reset clears state and output valid, and loads configuration reset values
module wheel_speed_controller_unit #(
    parameter int SPEED_FRAC_BITS = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,   // [12:0] target_speed, [28:13] measured_count
    input  logic [0:0]                          s_tuser,   // [0] clear_fault
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] duty
    output logic [2:0]                          m_tuser,   // [1:0] drive_dir, [2] fault
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wsc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import wsc_pkg::*;

    localparam int SCALE   = 100 << SPEED_FRAC_BITS;
    localparam int SCALE_W = $clog2(SCALE + 1);
    localparam int NUM_W   = MAG_W + 10;
    localparam int MS_W    = MEAS_W + SCALE_W;
    localparam int ERR_W   = ((NUM_W + 1 > MS_W) ? NUM_W + 1 : MS_W) + 1;
    localparam int MB_W    = 17;
    localparam int P_W     = ERR_W + MB_W;
    localparam int WANT_W  = P_W + 2;
    localparam int CMP_W   = ((MS_W + 8 > P_W) ? MS_W + 8 : P_W) + 1;
    localparam int THR_W   = ((MAG_W > 8 + SPEED_FRAC_BITS) ? MAG_W : 8 + SPEED_FRAC_BITS) + 1;
    localparam logic signed [ERR_W-1:0] SCALE_E = ERR_W'(SCALE);
    localparam logic signed [MB_W-1:0]  SCALE_B = MB_W'(SCALE);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PREP  = 4'd1;
    localparam logic [3:0] ST_NUM   = 4'd2;
    localparam logic [3:0] ST_MEAS  = 4'd3;
    localparam logic [3:0] ST_ERR   = 4'd4;
    localparam logic [3:0] ST_DEAD  = 4'd5;
    localparam logic [3:0] ST_KP    = 4'd6;
    localparam logic [3:0] ST_RATIO = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_WANT  = 4'd9;
    localparam logic [3:0] ST_SLEW  = 4'd10;

    // configuration
    logic [63:0] ff_table_reg;
    logic [15:0] gain_kp_reg;
    logic [15:0] pwm_limits_reg;
    logic [7:0]  slew_step_reg;
    logic [24:0] stall_reg;
    logic [9:0]  interval_reg;
    logic [1:0]  mode_reg;

    // sequencer and datapath
    logic [3:0]               state_reg, state_next;
    logic [TGT_W-1:0]         tgt_reg, tgt_next;
    logic [MEAS_W-1:0]        meas_reg, meas_next;
    logic                     clr_reg, clr_next;
    logic [7:0]               ff_reg, ff_next;
    logic signed [P_W-1:0]    prod_reg, prod_next;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic signed [MS_W-1:0]   ms_reg, ms_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic                     neg_reg, neg_next;
    logic [15:0]              want_reg, want_next;
    logic [15:0]              duty_level_reg, duty_level_next;
    logic [7:0]               stall_ticks_reg, stall_ticks_next;
    logic                     fault_reg, fault_next;
    logic                     m_valid_reg, m_valid_next;
    logic [DUTY_W-1:0]        m_duty_reg, m_duty_next;
    logic [DIR_W-1:0]         m_dir_reg, m_dir_next;
    logic                     m_fault_reg, m_fault_next;

    logic [MAG_W-1:0]         mag;
    logic [2:0]               band;
    logic signed [ERR_W-1:0]  mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [P_W-1:0]    mul_p;
    logic                     out_free;
    logic                     open_loop;
    logic                     fault_eff;
    logic [7:0]               ticks_eff;
    logic [P_W-1:0]           div_quo;
    logic [P_W-1:0]           div_in;
    logic                     div_start;
    div_status_t              div_stat;
    logic signed [WANT_W-1:0] q_s;
    logic signed [WANT_W-1:0] want_full;
    logic signed [WANT_W-1:0] lo_w, hi_w;
    logic signed [17:0]       lim, diff, diff_c;
    logic signed [18:0]       step_sum, lo_s, hi_s;
    logic [15:0]              cur;
    logic signed [CMP_W-1:0]  ms_cmp, nr_cmp;
    logic                     stall_cond;
    logic [7:0]               ticks_new;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_tready;
    assign open_loop = mode_reg[0];
    assign fault_eff = clr_reg ? 1'b0 : fault_reg;
    assign ticks_eff = clr_reg ? 8'd0 : stall_ticks_reg;
    assign mag       = tgt_reg[TGT_W-1] ? MAG_W'(~tgt_reg + 1'b1) : tgt_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ff_table_reg   <= RST_FF_TABLE;
            gain_kp_reg    <= RST_GAIN_KP;
            pwm_limits_reg <= RST_PWM_LIMITS;
            slew_step_reg  <= RST_SLEW_STEP;
            stall_reg      <= RST_STALL;
            interval_reg   <= RST_INTERVAL;
            mode_reg       <= RST_MODE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FF_TABLE:   ff_table_reg   <= cfg_data;
                REG_GAIN_KP:    gain_kp_reg    <= cfg_data[15:0];
                REG_PWM_LIMITS: pwm_limits_reg <= cfg_data[15:0];
                REG_SLEW_STEP:  slew_step_reg  <= cfg_data[7:0];
                REG_STALL:      stall_reg      <= cfg_data[24:0];
                REG_INTERVAL:   interval_reg   <= cfg_data[9:0];
                REG_MODE:       mode_reg       <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // speed band of the target magnitude
    always_comb begin
        band = 3'(NUM_BANDS - 1);
        for (int k = NUM_BANDS - 2; k >= 0; k--) begin
            if (THR_W'(mag) <= (THR_W'(BAND_TOP[k]) << SPEED_FRAC_BITS)) begin
                band = 3'(k);
            end
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_NUM: begin
                mul_a = $signed({{(ERR_W - MAG_W){1'b0}}, mag});
                mul_b = $signed({{(MB_W - 10){1'b0}}, interval_reg});
            end
            ST_MEAS: begin
                mul_a = ERR_W'($signed(meas_reg));
                mul_b = SCALE_B;
            end
            ST_KP: begin
                mul_a = err_reg;
                mul_b = $signed({1'b0, gain_kp_reg});
            end
            ST_RATIO: begin
                mul_a = $signed({{(ERR_W - NUM_W){1'b0}}, num_reg});
                mul_b = $signed({{(MB_W - 9){1'b0}}, stall_reg[24:16]});
            end
            default: ;
        endcase
    end
    assign mul_p = P_W'(mul_a) * P_W'(mul_b);

    assign div_start = (state_reg == ST_RATIO);
    assign div_in    = prod_reg[P_W-1] ? P_W'(-prod_reg) : P_W'(prod_reg);

    wsc_divider #(
        .DIVIDEND_W (P_W),
        .SHIFT      (SPEED_FRAC_BITS + 2)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_in),
        .quotient (div_quo),
        .status   (div_stat)
    );

    // feedforward plus proportional term (feedforward only in open loop), clamped
    assign q_s       = open_loop ? '0 :
                       (neg_reg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo}));
    assign want_full = WANT_W'($signed({1'b0, ff_reg, 8'h00})) + q_s;
    assign lo_w      = WANT_W'($signed({1'b0, pwm_limits_reg[7:0], 8'h00}));
    assign hi_w      = WANT_W'($signed({1'b0, pwm_limits_reg[15:8], 8'h00}));

    // slew limit and clamp, both bypassed in open loop
    assign lim      = $signed({2'b00, slew_step_reg, 8'h00});
    assign diff     = $signed({2'b00, want_reg}) - $signed({2'b00, duty_level_reg});
    assign diff_c   = (diff > lim) ? lim : ((diff < -lim) ? -lim : diff);
    assign step_sum = $signed({3'b000, duty_level_reg}) + 19'(diff_c);
    assign lo_s     = $signed({3'b000, pwm_limits_reg[7:0], 8'h00});
    assign hi_s     = $signed({3'b000, pwm_limits_reg[15:8], 8'h00});
    always_comb begin
        if (open_loop) begin
            cur = want_reg;
        end else if (step_sum < lo_s) begin
            cur = pwm_limits_reg[7:0] << 8;
        end else if (step_sum > hi_s) begin
            cur = pwm_limits_reg[15:8] << 8;
        end else begin
            cur = step_sum[15:0];
        end
    end

    // stall detection
    assign ms_cmp     = CMP_W'(ms_reg) <<< 8;
    assign nr_cmp     = CMP_W'(prod_reg);
    assign stall_cond = (cur > {stall_reg[7:0], 8'h00}) && (ms_cmp < nr_cmp);
    assign ticks_new  = stall_cond ? ((stall_ticks_reg == 8'hFF) ? 8'hFF : stall_ticks_reg + 8'd1)
                                   : 8'd0;

    always_comb begin
        state_next       = state_reg;
        tgt_next         = tgt_reg;
        meas_next        = meas_reg;
        clr_next         = clr_reg;
        ff_next          = ff_reg;
        prod_next        = prod_reg;
        num_next         = num_reg;
        ms_next          = ms_reg;
        err_next         = err_reg;
        neg_next         = neg_reg;
        want_next        = want_reg;
        duty_level_next  = duty_level_reg;
        stall_ticks_next = stall_ticks_reg;
        fault_next       = fault_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_duty_next      = m_duty_reg;
        m_dir_next       = m_dir_reg;
        m_fault_next     = m_fault_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    tgt_next   = s_tdata[TGT_W-1:0];
                    meas_next  = s_tdata[TGT_W+MEAS_W-1:TGT_W];
                    clr_next   = s_tuser[0];
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                fault_next       = fault_eff;
                stall_ticks_next = ticks_eff;
                ff_next          = ff_table_reg[band*8 +: 8];
                if (mag == '0 || fault_eff) begin
                    if (out_free) begin
                        duty_level_next = '0;
                        if (mag == '0) begin
                            stall_ticks_next = 8'd0;
                        end
                        m_valid_next = 1'b1;
                        m_duty_next  = '0;
                        m_dir_next   = DIR_OFF;
                        m_fault_next = fault_eff;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    state_next = ST_NUM;
                end
            end
            ST_NUM: begin
                prod_next  = mul_p;
                state_next = ST_MEAS;
            end
            ST_MEAS: begin
                num_next   = prod_reg[NUM_W-1:0];
                prod_next  = mul_p;
                state_next = ST_ERR;
            end
            ST_ERR: begin
                ms_next    = prod_reg[MS_W-1:0];
                err_next   = ERR_W'($signed({1'b0, num_reg})) - ERR_W'($signed(prod_reg[MS_W-1:0]));
                state_next = ST_DEAD;
            end
            ST_DEAD: begin
                // errors under one count are ignored
                if (err_reg < SCALE_E && err_reg > -SCALE_E) begin
                    err_next = '0;
                end
                state_next = ST_KP;
            end
            ST_KP: begin
                prod_next  = mul_p;
                state_next = ST_RATIO;
            end
            ST_RATIO: begin
                neg_next   = prod_reg[P_W-1];
                prod_next  = mul_p;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_WANT;
                end
            end
            ST_WANT: begin
                if (want_full < lo_w) begin
                    want_next = pwm_limits_reg[7:0] << 8;
                end else if (want_full > hi_w) begin
                    want_next = pwm_limits_reg[15:8] << 8;
                end else begin
                    want_next = want_full[15:0];
                end
                state_next = ST_SLEW;
            end
            ST_SLEW: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    duty_level_next = cur;
                    m_duty_next     = cur[15:8];
                    m_dir_next      = tgt_reg[TGT_W-1] ? DIR_REV : DIR_FWD;
                    m_fault_next    = fault_reg;
                    if (mode_reg[1]) begin
                        stall_ticks_next = ticks_new;
                        if (ticks_new >= stall_reg[15:8]) begin
                            fault_next      = 1'b1;
                            duty_level_next = '0;
                            m_duty_next     = '0;
                            m_dir_next      = DIR_OFF;
                            m_fault_next    = 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            duty_level_reg  <= '0;
            stall_ticks_reg <= '0;
            fault_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            duty_level_reg  <= duty_level_next;
            stall_ticks_reg <= stall_ticks_next;
            fault_reg       <= fault_next;
            m_valid_reg     <= m_valid_next;
        end
        tgt_reg     <= tgt_next;
        meas_reg    <= meas_next;
        clr_reg     <= clr_next;
        ff_reg      <= ff_next;
        prod_reg    <= prod_next;
        num_reg     <= num_next;
        ms_reg      <= ms_next;
        err_reg     <= err_next;
        neg_reg     <= neg_next;
        want_reg    <= want_next;
        m_duty_reg  <= m_duty_next;
        m_dir_reg   <= m_dir_next;
        m_fault_reg <= m_fault_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_duty_reg;
    assign m_tuser  = {m_fault_reg, m_dir_reg};

endmodule

/* hw/rtl/wsc_divider.sv */
// wsc_divider: magnitude divided by 25 * 2^SHIFT by a reciprocal multiply, result registered
// quotient saturates at 65536, above any clamped duty; depends on wsc_pkg for the status struct
module wsc_divider #(
    parameter int DIVIDEND_W = 45,
    parameter int SHIFT      = 6
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [DIVIDEND_W-1:0]   dividend,
    output logic [DIVIDEND_W-1:0]   quotient,
    output wsc_pkg::div_status_t    status
);
    import wsc_pkg::*;

    localparam int X_W      = 21;
    localparam int RECIP_W  = 22;
    localparam int PROD_W   = X_W + RECIP_W;
    localparam int RECIP_SH = 26;
    localparam int Q_W      = 17;
    // ceil(2^26 / 25), exact for every 21-bit value
    localparam logic [RECIP_W-1:0] RECIP = 22'd2684355;
    // 65536 * 25
    localparam logic [X_W-1:0]     X_SAT = 21'd1638400;

    logic [DIVIDEND_W-1:0] shifted;
    logic [X_W-1:0]        x_sat;
    logic [PROD_W-1:0]     recip_prod;
    logic [Q_W-1:0]        quo_reg, quo_next;
    logic                  done_reg, done_next;

    assign shifted    = dividend >> SHIFT;
    assign x_sat      = (shifted >= DIVIDEND_W'(X_SAT)) ? X_SAT : shifted[X_W-1:0];
    assign recip_prod = PROD_W'(x_sat) * PROD_W'(RECIP);
    assign quo_next   = start ? recip_prod[RECIP_SH +: Q_W] : quo_reg;
    assign done_next  = start;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
    end

    assign quotient    = DIVIDEND_W'(quo_reg);
    assign status.busy = 1'b0;
    assign status.done = done_reg;

endmodule

/* hw/rtl/wsc_checker.sv */
// wsc_checker: port-level checks of the wheel speed controller
// depends on wsc_pkg; bound to wheel_speed_controller_unit below
module wsc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [31:0]                     s_tdata,
    input logic [0:0]                      s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [7:0]                      m_tdata,
    input logic [2:0]                      m_tuser,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [wsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [wsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wsc_pkg::*;

    // one word at a time: input closes right after a word is taken
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in flight");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_off_zero_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == DIR_OFF |-> m_tdata == 8'd0)
        else $error("nonzero duty with drive off");

    a_fault_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] == DIR_OFF)
        else $error("drive active with fault latched");

    a_dir_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[1:0] == DIR_OFF || m_tuser[1:0] == DIR_FWD ||
                     m_tuser[1:0] == DIR_REV)
        else $error("undefined drive direction");

endmodule

bind wheel_speed_controller_unit wsc_checker u_wsc_checker (.*);
